@@ hw/rtl/sorted_list_insert_remove_core_defines.svh @@
// ----------------------------------------------------------------------------
// sorted list core assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// same-cycle implication
`define SLI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg
// types and codes shared by the sorted list core
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN_INS,
    BK_PLACE,
    BK_SCAN_REM,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sli_front.sv @@
// ----------------------------------------------------------------------------
// sli_front
// accepts requests, decodes the operation and hands them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module sli_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic signed [sli_pkg::VALUE_W-1:0] in_value,
  output logic                               push,
  output sli_pkg::req_t                      push_req,
  input  wire logic                          q_full
);
  import sli_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r, req_nxt;
  logic accept;

  assign in_stall = valid_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = valid_r & ~q_full;
  assign push_req = req_r;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (accept) begin
      valid_nxt     = 1'b1;
      req_nxt.op    = in_func ? OP_REMOVE : OP_INSERT;
      req_nxt.value = in_value;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sli_queue.sv @@
// ----------------------------------------------------------------------------
// sli_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sli_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire sli_pkg::req_t push_req,
  output logic        q_full,
  input  wire logic   pop,
  output logic        q_valid,
  output sli_pkg::req_t q_req
);
  import sli_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign q_full  = (fill_r == 2'd2);
  assign q_valid = (fill_r != 2'd0);
  assign q_req   = slot_r[rd_ptr_r];
  assign do_push = push & ~q_full;
  assign do_pop  = pop & q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sli_back.sv @@
// ----------------------------------------------------------------------------
// sli_back
// executes insert and remove against the entry memory, one entry a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sli_back #(
  parameter int DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire sli_pkg::req_t q_req,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [1:0]  out_status,
  output logic [sli_pkg::COUNT_W-1:0] out_count
);
  import sli_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rdata_r;

  back_state_t state_r, state_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  status_t     status_r, status_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [IW-1:0] raddr;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic          out_load;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] keep_fin;
  logic          is_full, is_last, hit;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign cnt_m1   = cnt_r - 1'b1;
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_last  = (CW'(idx_r) == cnt_m1);
  assign hit      = (rdata_r == value_r);
  assign keep_fin = hit ? keep_r : keep_r + 1'b1;
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_r};
  assign out_load = (state_r == BK_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_req.op == OP_INSERT) begin
            state_nxt = (is_full || cnt_r == '0) ? BK_DONE : BK_SCAN_INS;
          end else begin
            state_nxt = (cnt_r == '0) ? BK_DONE : BK_SCAN_REM;
          end
        end
      end
      BK_SCAN_INS: begin
        if (rdata_r < value_r) begin
          state_nxt = BK_DONE;
        end else if (idx_r == '0) begin
          state_nxt = BK_PLACE;
        end
      end
      BK_PLACE:    state_nxt = BK_DONE;
      BK_SCAN_REM: begin
        if (is_last) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop        = 1'b0;
    value_nxt  = value_r;
    idx_nxt    = idx_r;
    keep_nxt   = keep_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = value_r;
    raddr      = idx_r;
    case (state_r)
      BK_IDLE: begin
        raddr = '0;
        if (q_valid) begin
          pop       = 1'b1;
          value_nxt = q_req.value;
          keep_nxt  = '0;
          if (q_req.op == OP_INSERT) begin
            status_nxt = ST_DONE;
            if (is_full) begin
              status_nxt = ST_FULL;
            end else if (cnt_r == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = q_req.value;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              idx_nxt = cnt_m1[IW-1:0];
              raddr   = cnt_m1[IW-1:0];
            end
          end else begin
            idx_nxt = '0;
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end
          end
        end
      end
      BK_SCAN_INS: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + 1'b1;
        raddr     = idx_r - 1'b1;
        if (rdata_r < value_r) begin
          mem_wdata = value_r;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          mem_wdata = rdata_r;
          idx_nxt   = idx_r - 1'b1;
        end
      end
      BK_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = value_r;
        cnt_nxt   = cnt_r + 1'b1;
      end
      BK_SCAN_REM: begin
        raddr     = idx_r + 1'b1;
        mem_we    = ~hit;
        mem_waddr = keep_r[IW-1:0];
        mem_wdata = rdata_r;
        keep_nxt  = keep_fin;
        idx_nxt   = idx_r + 1'b1;
        if (is_last) begin
          if (keep_fin == cnt_r) begin
            status_nxt = ST_NOTFOUND;
          end else begin
            status_nxt = ST_DONE;
            cnt_nxt    = keep_fin;
          end
        end
      end
      BK_DONE: ;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_count_nxt  = cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    keep_r       <= keep_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_list_insert_remove_core.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core
// ascending list of signed Q16.16 values with insert and remove-all-equal
// ----------------------------------------------------------------------------
//   channel | ports                              | flow
//   --------+------------------------------------+-----------------------
//   in      | in_valid in_stall in_func in_value | request into the core
//   out     | out_valid out_stall out_status     | one result per request
//           | out_count                          |
//
// the back unit handles a request with one memory read per entry scanned,
// as the entry memory has a single read port.
// a two-entry queue lets the front keep taking requests while the back works.
// reset clears the count and the control state; entry memory is not cleared.
// a stalled result holds in the output register while the back runs on.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_func,
  input  wire logic signed [sli_pkg::VALUE_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic [sli_pkg::COUNT_W-1:0]             out_count
);
  import sli_pkg::*;

  logic push, q_full, pop, q_valid;
  req_t push_req, q_req;

  sli_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_value (in_value),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full)
  );

  sli_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  sli_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sli_checker.sv @@
// ----------------------------------------------------------------------------
// sli_checker
// port-level checks on the sorted list core
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_remove_core_defines.svh"

module sli_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [1:0]                 out_status,
  input wire logic [sli_pkg::COUNT_W-1:0] out_count
);
  import sli_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

  `SLI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SLI_ASSERT_NXT(a_out_stable, out_valid && out_stall,
    $stable(out_status) && $stable(out_count), "result changed while stalled")
  `SLI_ASSERT_IMP(a_full_count, out_valid && out_status == ST_FULL,
    out_count == FULL_CNT, "full status with count below depth")
  `SLI_ASSERT_IMP(a_empty_count, out_valid && out_status == ST_EMPTY,
    out_count == '0, "empty status with nonzero count")

endmodule

bind sorted_list_insert_remove_core sli_checker #(.DEPTH(DEPTH)) u_sli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_count  (out_count)
);

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// sorted list core testbench
// Sends insert and remove requests to the core and keeps its own sorted copy
// of the list, which gives the expected status and count of every request.
// Each result is checked in order against that copy. Coverage comes from
// three parts: a short directed part with field extremes, a full list,
// duplicates and every status; random traffic under several idle and stall
// mixes; and a long output hold that makes the core stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sli_pkg::*;

  localparam int DEPTH       = 16;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;

  localparam logic signed [VALUE_W-1:0] FILL_VALS [16] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0001_0000, 32'sh0000_0000, 32'shFFFF_0000, 32'sh0000_8000,
    32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
    32'sh1234_5678, 32'shEDCB_A988, 32'sh0000_0002, 32'shFFFF_FFFE
  };

  typedef struct {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      in_func   = 1'b0;
  logic signed [VALUE_W-1:0] in_value  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_status;
  logic [COUNT_W-1:0]        out_count;

  logic signed [VALUE_W-1:0] held_values[$];
  list_result_t              pending_results[$];

  int send_idle_pct = 18;
  int stall_pct     = 80;
  bit hold_req      = 1'b0;
  int errors        = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int idle_cycles   = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  always #4 clk = ~clk;

  sorted_list_insert_remove_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // updates the sorted copy and returns the status of one request
  function automatic status_t apply_request(op_t op, logic signed [VALUE_W-1:0] v);
    int                        pos;
    logic signed [VALUE_W-1:0] survivors[$];
    pos = 0;
    if (op == OP_INSERT) begin
      if (held_values.size() >= DEPTH) return ST_FULL;
      while (pos < held_values.size() && v > held_values[pos]) pos++;
      held_values.insert(pos, v);
      return ST_DONE;
    end
    if (held_values.size() == 0) return ST_EMPTY;
    foreach (held_values[k]) begin
      if (held_values[k] != v) survivors.push_back(held_values[k]);
    end
    if (survivors.size() == held_values.size()) return ST_NOTFOUND;
    held_values = survivors;
    return ST_DONE;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(1) == 0) return $urandom;
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      4:       return 32'sh0001_0000;
      5:       return 32'shFFFF_0000;
      6:       return 32'sh0000_8000;
      default: return 32'sh0000_0001;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_request(op_t op, logic signed [VALUE_W-1:0] v);
    list_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_func  <= 1'($urandom);
      in_value <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= op;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r.status = apply_request(op, v);
    r.count  = COUNT_W'(held_values.size());
    pending_results.push_back(r);
    status_seen[r.status]++;
    n_requests++;
    @(negedge clk);
  endtask

  task automatic send_random_request(int insert_pct);
    op_t                       op;
    logic signed [VALUE_W-1:0] v;
    op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    if (op == OP_REMOVE && held_values.size() != 0 && $urandom_range(99) < 70)
      v = held_values[$urandom_range(held_values.size() - 1)];
    else
      v = pick_value();
    send_request(op, v);
  endtask

  task automatic test_remove_on_empty();
    send_request(OP_REMOVE, 32'sh0000_0000);
  endtask

  task automatic test_fill_and_full();
    foreach (FILL_VALS[k]) send_request(OP_INSERT, FILL_VALS[k]);
    send_request(OP_INSERT, 32'sh5555_5555);
    send_request(OP_INSERT, 32'sh8000_0000);
  endtask

  task automatic test_remove_cases();
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_REMOVE, 32'sh0000_0000);
    send_request(OP_REMOVE, 32'sh7FFF_FFFF);
    send_request(OP_REMOVE, 32'sh8000_0000);
    send_request(OP_REMOVE, 32'shAAAA_AAAA);
  endtask

  // insert bias swings so the list sweeps between empty and full
  task automatic run_random_phase(int n_items, int idle_pct, int stall_pc);
    send_idle_pct = idle_pct;
    stall_pct     = stall_pc;
    for (int i = 0; i < n_items; i++) send_random_request(((i / 48) % 2 == 0) ? 75 : 30);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    repeat (24) send_random_request(60);
  endtask

  initial begin : receiver
    int k;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d count %0d", out_status, out_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, out_status);
          errors++;
        end
        if (out_count !== want.count) begin
          $error("count mismatch: expected %0d actual %0d", want.count, out_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_remove_on_empty();
    test_fill_and_full();
    test_remove_cases();
    run_random_phase(430, 18, 80);
    run_random_phase(430, 80, 18);
    test_backpressure();
    run_random_phase(440, 0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    $display("ran %0d requests through insert and remove, %0d results checked",
             n_requests, n_results);
    $display("outcomes: %0d done, %0d full, %0d empty, %0d not found",
             status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sorted_list_insert_remove_core.f @@
+incdir+hw/rtl
hw/rtl/sli_pkg.sv
hw/rtl/sli_front.sv
hw/rtl/sli_queue.sv
hw/rtl/sli_back.sv
hw/rtl/sorted_list_insert_remove_core.sv
hw/rtl/sli_checker.sv
sim/testbench.sv
